// ===== src/nsfp_pkg.sv =====
// Package for the NMEA sentence field parser: payload types, codes, lookup functions.
package nsfp_pkg;

  // Input transfer payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_sentence;
  } nsfp_in_t;

  // Result transfer payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] field_kind;
    logic       field_first;
    logic       sentence_done;
    logic [7:0] checksum_value;
    logic [2:0] talker_code;
    logic [3:0] sentence_code;
    logic       is_valid;
  } nsfp_out_t;

  // Field kinds
  localparam logic [2:0] KIND_SUMMARY = 3'd0;
  localparam logic [2:0] KIND_TIME    = 3'd1;
  localparam logic [2:0] KIND_LAT     = 3'd2;
  localparam logic [2:0] KIND_LON     = 3'd3;
  localparam logic [2:0] KIND_ALT     = 3'd4;
  localparam logic [2:0] KIND_DATE    = 3'd5;

  // Talker codes
  localparam int unsigned NUM_TALKERS = 6;
  localparam logic [2:0] TALKER_UNKNOWN = 3'd6;

  // Sentence type codes
  localparam int unsigned NUM_TYPES = 8;
  localparam logic [3:0] TYPE_ZDA     = 4'd0;
  localparam logic [3:0] TYPE_RMC     = 4'd1;
  localparam logic [3:0] TYPE_GGA     = 4'd2;
  localparam logic [3:0] TYPE_GNS     = 4'd4;
  localparam logic [3:0] TYPE_GLL     = 4'd5;
  localparam logic [3:0] TYPE_UNKNOWN = 4'd8;

  // Special characters
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;

  // Header length: '$' plus five header characters
  localparam logic [2:0] HDR_LEN   = 3'd6;
  localparam logic [3:0] FIELD_MAX = 4'd15;

  // Name tables, first character in the top byte
  localparam logic [15:0] TALKER_NAMES [NUM_TALKERS] = '{
    "GP", "GN", "GA", "GB", "BD", "GL"
  };
  localparam logic [23:0] TYPE_NAMES [NUM_TYPES] = '{
    "ZDA", "RMC", "GGA", "VTG", "GNS", "GLL", "GSV", "GSA"
  };

  // hdr holds header position p in bits 8*(p-1) upwards
  function automatic logic [2:0] talker_of(input logic [39:0] hdr);
    logic [2:0]  code;
    logic [15:0] pair;
    code = TALKER_UNKNOWN;
    pair = {hdr[7:0], hdr[15:8]};
    for (int i = 0; i < NUM_TALKERS; i++) begin
      if (pair == TALKER_NAMES[i]) code = 3'(i);
    end
    return code;
  endfunction

  function automatic logic [3:0] type_of(input logic [39:0] hdr);
    logic [3:0]  code;
    logic [23:0] trio;
    code = TYPE_UNKNOWN;
    trio = {hdr[23:16], hdr[31:24], hdr[39:32]};
    for (int i = 0; i < NUM_TYPES; i++) begin
      if (trio == TYPE_NAMES[i]) code = 4'(i);
    end
    return code;
  endfunction

  // Field kind for a sentence type and comma-delimited field number
  function automatic logic [2:0] kind_of(input logic [3:0] ty, input logic [3:0] f);
    logic [2:0] k;
    k = KIND_SUMMARY;
    case (ty)
      TYPE_RMC: begin
        if (f == 4'd1) k = KIND_TIME;
        else if (f inside {4'd3, 4'd4}) k = KIND_LAT;
        else if (f inside {4'd5, 4'd6}) k = KIND_LON;
        else if (f == 4'd9) k = KIND_DATE;
      end
      TYPE_GGA, TYPE_GNS: begin
        if (f == 4'd1) k = KIND_TIME;
        else if (f inside {4'd2, 4'd3}) k = KIND_LAT;
        else if (f inside {4'd4, 4'd5}) k = KIND_LON;
        else if (f == 4'd9) k = KIND_ALT;
      end
      TYPE_ZDA: begin
        if (f == 4'd1) k = KIND_TIME;
        else if (f inside {[4'd2:4'd4]}) k = KIND_DATE;
      end
      TYPE_GLL: begin
        if (f inside {4'd1, 4'd2}) k = KIND_LAT;
        else if (f inside {4'd3, 4'd4}) k = KIND_LON;
        else if (f == 4'd5) k = KIND_TIME;
      end
      default: k = KIND_SUMMARY;
    endcase
    return k;
  endfunction

endpackage

// ===== src/nmea_sentence_field_parser.sv =====
// NMEA sentence parser: checksum, header decode and field character extraction.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+-----------------------------------
//   in_     | input     | in_valid / in_ready  | in_data  (data_byte, end_of_sentence)
//   out_    | output    | out_valid / out_ready| out_data (field char or summary)
//
// One input transfer per cycle while in_ready is high. A character or
// terminator is folded into the state in the cycle it is accepted; any result
// it yields appears in the output register on the next cycle. The single
// result register sets the rate: in_ready is high while that register is empty
// or being taken, so a stalled result holds back all input until taken.
// Reset (rst_n low, synchronous) clears the sentence state and empties the
// result register. A terminator also clears the sentence state.
module nmea_sentence_field_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  nsfp_pkg::nsfp_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output nsfp_pkg::nsfp_out_t out_data
);
  import nsfp_pkg::*;

  // Sentence state
  logic [7:0]  xor_r,        xor_nxt;
  logic [2:0]  char_cnt_r,   char_cnt_nxt;
  logic        dollar_r,     dollar_nxt;
  logic        star_r,       star_nxt;
  logic [39:0] hdr_r,        hdr_nxt;
  logic [3:0]  field_idx_r,  field_idx_nxt;
  logic [2:0]  last_kind_r,  last_kind_nxt;

  // Result register
  logic        out_valid_r,  out_valid_nxt;
  nsfp_out_t   out_data_r,   out_data_nxt;

  logic        in_xfer;
  logic        emit;
  logic [2:0]  talker;
  logic [3:0]  stype;
  logic [2:0]  kind;
  logic [7:0]  b;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign b        = in_data.data_byte;

  // Character update of the header, checksum and counters
  always_comb begin
    xor_nxt       = xor_r;
    char_cnt_nxt  = char_cnt_r;
    dollar_nxt    = dollar_r;
    star_nxt      = star_r;
    hdr_nxt       = hdr_r;
    field_idx_nxt = field_idx_r;

    if (char_cnt_r == 3'd0 && b == CHAR_DOLLAR) begin
      dollar_nxt = 1'b1;
    end else if (b == CHAR_STAR) begin
      star_nxt = 1'b1;
    end else if (!star_r) begin
      xor_nxt = xor_r ^ b;
    end

    // header positions 1..5 fill byte lanes 0..4
    case (char_cnt_r)
      3'd1:    hdr_nxt[7:0]   = b;
      3'd2:    hdr_nxt[15:8]  = b;
      3'd3:    hdr_nxt[23:16] = b;
      3'd4:    hdr_nxt[31:24] = b;
      3'd5:    hdr_nxt[39:32] = b;
      default: hdr_nxt        = hdr_r;
    endcase
    if (char_cnt_r < HDR_LEN) char_cnt_nxt = char_cnt_r + 3'd1;

    if (b == CHAR_COMMA && field_idx_r < FIELD_MAX) field_idx_nxt = field_idx_r + 4'd1;
  end

  // Decode runs on the updated header so the fifth header char counts at once
  always_comb begin
    logic [39:0] hdr_sel;
    hdr_sel = in_data.end_of_sentence ? hdr_r : hdr_nxt;
    talker  = talker_of(hdr_sel);
    stype   = type_of(hdr_sel);
    kind    = kind_of(stype, field_idx_r);
  end

  // Commas separate fields and are never passed on
  assign emit = in_data.end_of_sentence || (b != CHAR_COMMA && kind != KIND_SUMMARY);

  always_comb begin
    out_data_nxt = '0;
    if (in_data.end_of_sentence) begin
      out_data_nxt.sentence_done  = 1'b1;
      out_data_nxt.checksum_value = xor_r;
      out_data_nxt.talker_code    = talker;
      out_data_nxt.sentence_code  = stype;
      out_data_nxt.is_valid       = dollar_r && star_r && (char_cnt_r >= HDR_LEN) &&
                                    (talker != TALKER_UNKNOWN) && (stype != TYPE_UNKNOWN);
    end else begin
      out_data_nxt.out_byte       = b;
      out_data_nxt.field_kind     = kind;
      out_data_nxt.field_first    = (kind != last_kind_r);
      out_data_nxt.checksum_value = xor_nxt;
      out_data_nxt.talker_code    = talker;
      out_data_nxt.sentence_code  = stype;
    end
  end

  always_comb begin
    last_kind_nxt = last_kind_r;
    if (!in_data.end_of_sentence && emit) last_kind_nxt = kind;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (in_xfer) out_valid_nxt = emit;
  end

  // Control and sentence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_r       <= '0;
      char_cnt_r  <= '0;
      dollar_r    <= 1'b0;
      star_r      <= 1'b0;
      hdr_r       <= '0;
      field_idx_r <= '0;
      last_kind_r <= KIND_SUMMARY;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        if (in_data.end_of_sentence) begin
          // terminator: start afresh for the next sentence
          xor_r       <= '0;
          char_cnt_r  <= '0;
          dollar_r    <= 1'b0;
          star_r      <= 1'b0;
          hdr_r       <= '0;
          field_idx_r <= '0;
          last_kind_r <= KIND_SUMMARY;
        end else begin
          xor_r       <= xor_nxt;
          char_cnt_r  <= char_cnt_nxt;
          dollar_r    <= dollar_nxt;
          star_r      <= star_nxt;
          hdr_r       <= hdr_nxt;
          field_idx_r <= field_idx_nxt;
          last_kind_r <= last_kind_nxt;
        end
      end
    end
  end

  // Result payload, loaded only on a producing transfer
  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A terminator always yields a summary on the next cycle
  a_eos_summary: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_data.end_of_sentence |=> out_valid && out_data.sentence_done)
    else $error("terminator did not produce a summary result");

  // Sentence state is cleared after a terminator
  a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_data.end_of_sentence |=>
      char_cnt_r == 3'd0 && field_idx_r == 4'd0 && xor_r == 8'd0 && hdr_r == 40'd0)
    else $error("sentence state not cleared after terminator");

  // Summary and field results are told apart consistently
  a_summary_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.sentence_done |->
      out_data.field_kind == KIND_SUMMARY && out_data.out_byte == 8'd0 &&
      !out_data.field_first)
    else $error("summary result carries field data");

  a_field_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.sentence_done |->
      out_data.field_kind != KIND_SUMMARY && !out_data.is_valid &&
      out_data.out_byte != CHAR_COMMA)
    else $error("field result malformed");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the NMEA sentence field parser.
`timescale 1ns / 1ps

module testbench;
  import nsfp_pkg::*;

  // Talker and sentence codes that the package leaves unnamed
  localparam logic [2:0] TK_GP = 3'd0;
  localparam logic [2:0] TK_GN = 3'd1;
  localparam logic [2:0] TK_GA = 3'd2;
  localparam logic [2:0] TK_GB = 3'd3;
  localparam logic [2:0] TK_BD = 3'd4;
  localparam logic [2:0] TK_GL = 3'd5;
  localparam logic [3:0] SC_VTG = 4'd3;
  localparam logic [3:0] SC_GSV = 4'd6;
  localparam logic [3:0] SC_GSA = 4'd7;

  // Cycles without any transfer before the run is declared hung. The worst
  // honest wait is the longest sender gap plus a receiver stall.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_CAP      = 40;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  nsfp_in_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  nsfp_out_t  out_data;

  nmea_sentence_field_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Sentence predictor: its own copy of the parser state, updated once per
  // accepted input transfer. Parsed results queue up in arrival order.
  // ---------------------------------------------------------------------------
  logic [7:0]  xor_acc     = '0;
  logic [2:0]  n_chars     = '0;  // saturates at HDR_LEN
  logic        saw_dollar  = 1'b0;
  logic        saw_star    = 1'b0;
  logic [39:0] hdr_bytes   = '0;  // header char p in bits 8*(p-1) upwards
  logic [3:0]  comma_count = '0;  // saturates at FIELD_MAX
  logic [2:0]  prev_kind   = KIND_SUMMARY;

  nsfp_out_t parsed_q[$];
  int        mismatches = 0;
  int        items_sent = 0;

  // Talker pair is header positions 1 and 2, matched exactly
  function automatic logic [2:0] decode_talker(input logic [39:0] h);
    case ({h[7:0], h[15:8]})
      "GP":    return TK_GP;
      "GN":    return TK_GN;
      "GA":    return TK_GA;
      "GB":    return TK_GB;
      "BD":    return TK_BD;
      "GL":    return TK_GL;
      default: return TALKER_UNKNOWN;
    endcase
  endfunction

  // Sentence type is header positions 3 to 5
  function automatic logic [3:0] decode_type(input logic [39:0] h);
    case ({h[23:16], h[31:24], h[39:32]})
      "ZDA":   return TYPE_ZDA;
      "RMC":   return TYPE_RMC;
      "GGA":   return TYPE_GGA;
      "VTG":   return SC_VTG;
      "GNS":   return TYPE_GNS;
      "GLL":   return TYPE_GLL;
      "GSV":   return SC_GSV;
      "GSA":   return SC_GSA;
      default: return TYPE_UNKNOWN;
    endcase
  endfunction

  // Which kind of field, if any, a comma-delimited position carries
  function automatic logic [2:0] field_kind_at(input logic [3:0] ty, input logic [3:0] f);
    logic [2:0] k;
    k = KIND_SUMMARY;
    case (ty)
      TYPE_RMC: begin
        case (f)
          4'd1:       k = KIND_TIME;
          4'd3, 4'd4: k = KIND_LAT;
          4'd5, 4'd6: k = KIND_LON;
          4'd9:       k = KIND_DATE;
          default:    k = KIND_SUMMARY;
        endcase
      end
      TYPE_GGA, TYPE_GNS: begin
        case (f)
          4'd1:       k = KIND_TIME;
          4'd2, 4'd3: k = KIND_LAT;
          4'd4, 4'd5: k = KIND_LON;
          4'd9:       k = KIND_ALT;
          default:    k = KIND_SUMMARY;
        endcase
      end
      TYPE_ZDA: begin
        case (f)
          4'd1:             k = KIND_TIME;
          4'd2, 4'd3, 4'd4: k = KIND_DATE;
          default:          k = KIND_SUMMARY;
        endcase
      end
      TYPE_GLL: begin
        case (f)
          4'd1, 4'd2: k = KIND_LAT;
          4'd3, 4'd4: k = KIND_LON;
          4'd5:       k = KIND_TIME;
          default:    k = KIND_SUMMARY;
        endcase
      end
      default: k = KIND_SUMMARY;
    endcase
    return k;
  endfunction

  // Fold one character or terminator into the state; returns 1 with the
  // result filled in when the transfer yields one.
  function automatic bit parse_char(input nsfp_in_t item, output nsfp_out_t res);
    logic [7:0] b;
    logic [2:0] kind;
    logic [2:0] tk;
    logic [3:0] ty;
    int         slot;
    b   = item.data_byte;
    res = '0;
    tk  = decode_talker(hdr_bytes);
    ty  = decode_type(hdr_bytes);
    if (item.end_of_sentence) begin
      res.field_kind     = KIND_SUMMARY;
      res.sentence_done  = 1'b1;
      res.checksum_value = xor_acc;
      res.talker_code    = tk;
      res.sentence_code  = ty;
      res.is_valid       = saw_dollar && saw_star && (n_chars >= HDR_LEN) &&
                           (tk != TALKER_UNKNOWN) && (ty != TYPE_UNKNOWN);
      // terminator wipes the whole sentence state
      xor_acc     = '0;
      n_chars     = '0;
      saw_dollar  = 1'b0;
      saw_star    = 1'b0;
      hdr_bytes   = '0;
      comma_count = '0;
      prev_kind   = KIND_SUMMARY;
      return 1'b1;
    end

    // '$' only counts in the very first slot; after '*' the XOR is frozen
    if (n_chars == 3'd0 && b == CHAR_DOLLAR) saw_dollar = 1'b1;
    else if (b == CHAR_STAR) saw_star = 1'b1;
    else if (!saw_star) xor_acc = xor_acc ^ b;

    if (n_chars >= 3'd1 && n_chars <= 3'd5) begin
      slot = int'(n_chars) - 1;
      hdr_bytes[8*slot +: 8] = hdr_bytes[8*slot +: 8] | b;
    end
    if (n_chars < HDR_LEN) n_chars = n_chars + 3'd1;

    if (b == CHAR_COMMA) begin
      if (comma_count != FIELD_MAX) comma_count = comma_count + 4'd1;
      return 1'b0;
    end

    ty   = decode_type(hdr_bytes);
    kind = field_kind_at(ty, comma_count);
    if (kind == KIND_SUMMARY) return 1'b0;

    res.out_byte       = b;
    res.field_kind     = kind;
    res.field_first    = (kind != prev_kind);
    res.checksum_value = xor_acc;
    res.talker_code    = decode_talker(hdr_bytes);
    res.sentence_code  = ty;
    prev_kind          = kind;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of back-to-back transfers separated by random gaps. Valid
  // stays high across a burst, so it is only ever lowered at the start of a
  // non-zero gap or by settle, never in the step that raises it.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_max    = 4;

  task automatic send_item(input logic [7:0] b, input logic eos);
    int        gap;
    nsfp_out_t res;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, end_of_sentence: eos};
    do @(posedge clk); while (!in_ready);
    if (parse_char('{data_byte: b, end_of_sentence: eos}, res)) parsed_q.push_back(res);
    items_sent++;
    burst_left--;
  endtask

  // Drop valid and wait until every parsed result has come out
  task automatic settle();
    in_valid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (parsed_q.size() != 0);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // data byte on a terminator is don't-care, so randomise it
  task automatic close_sentence();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a mode that changes at random intervals -
  // always ready, coin toss, mostly stalled, or one slot in eight.
  // ---------------------------------------------------------------------------
  logic [1:0] rx_mode = 2'd0;
  int         rx_left = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= 2'($urandom_range(0, 3));
      rx_left <= $urandom_range(32, 256);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= 1'($urandom_range(0, 1));
      2'd2:    out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (rx_left % 8 == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checking, field by field against the oldest parsed result
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    nsfp_out_t want;
    string     diff;
    if (rst_n && out_valid && out_ready) begin
      if (parsed_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing outstanding", out_data));
      end else begin
        want = parsed_q.pop_front();
        diff = "";
        if (out_data.out_byte       !== want.out_byte)       diff = {diff, " out_byte"};
        if (out_data.field_kind     !== want.field_kind)     diff = {diff, " field_kind"};
        if (out_data.field_first    !== want.field_first)    diff = {diff, " field_first"};
        if (out_data.sentence_done  !== want.sentence_done)  diff = {diff, " sentence_done"};
        if (out_data.checksum_value !== want.checksum_value) diff = {diff, " checksum_value"};
        if (out_data.talker_code    !== want.talker_code)    diff = {diff, " talker_code"};
        if (out_data.sentence_code  !== want.sentence_code)  diff = {diff, " sentence_code"};
        if (out_data.is_valid       !== want.is_valid)       diff = {diff, " is_valid"};
        if (diff != "")
          report_mismatch($sformatf("wrong%s: got %h, want %h", diff, out_data, want));
      end
    end
  end

  // Watchdog: any transfer on either channel resets the count
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Terminator straight after reset: zero checksum, unknown codes, not valid
  task automatic test_empty_sentence();
    gap_max = 0;
    close_sentence();
    settle();
  endtask

  // All-zero and all-ones bytes as ordinary characters, no leading '$',
  // header cut short so the empty slots match nothing
  task automatic test_byte_extremes();
    gap_max = 3;
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    close_sentence();
    settle();
  endtask

  // A field that runs into '*' passes the star on; it stays out of the XOR
  task automatic test_star_inside_field();
    gap_max = 2;
    send_text("$GLGLL,*Z,4");
    close_sentence();
    settle();
  endtask

  // Seventeen commas: the field count must stick at its ceiling rather than
  // wrap round to the time field
  task automatic test_comma_saturation();
    gap_max = 0;
    send_text("$GPGGA,,,,,,,,,,,,,,,,,7");
    close_sentence();
    settle();
  endtask

  // Mostly well-formed sentences with random content. Sentence types and
  // talkers are walked in turn so every one is seen; now and then the header
  // is garbled, '$' or '*' is missing, text follows the star, a stray byte
  // lands in a field or the sentence is cut short.
  task automatic send_random_sentence(input int seq);
    logic [7:0] line_q[$];
    string      field_chars;
    string      ids;
    int         n_fields;
    int         cut;
    field_chars = "0123456789.NSEWAVMK-";
    case ($urandom_range(0, 3))
      0:       gap_max = 0;
      1:       gap_max = 2;
      2:       gap_max = 6;
      default: gap_max = 15;
    endcase

    line_q.push_back(($urandom_range(0, 15) != 0) ? CHAR_DOLLAR : 8'($urandom_range(0, 255)));

    if ($urandom_range(0, 9) != 0) begin
      case (seq % 6)
        0:       ids = "GP";
        1:       ids = "GN";
        2:       ids = "GA";
        3:       ids = "GB";
        4:       ids = "BD";
        default: ids = "GL";
      endcase
      line_q.push_back(ids[0]);
      line_q.push_back(ids[1]);
    end else begin
      repeat (2) line_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
    end

    if ($urandom_range(0, 9) != 0) begin
      case (seq % 8)
        0:       ids = "ZDA";
        1:       ids = "RMC";
        2:       ids = "GGA";
        3:       ids = "VTG";
        4:       ids = "GNS";
        5:       ids = "GLL";
        6:       ids = "GSV";
        default: ids = "GSA";
      endcase
      for (int i = 0; i < 3; i++) line_q.push_back(ids[i]);
    end else begin
      repeat (3) line_q.push_back(8'($urandom_range(0, 255)));
    end

    n_fields = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 18) : $urandom_range(1, 10);
    for (int f = 0; f < n_fields; f++) begin
      line_q.push_back(CHAR_COMMA);
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 19) == 0) line_q.push_back(8'($urandom_range(0, 255)));
        else line_q.push_back(field_chars[$urandom_range(0, field_chars.len() - 1)]);
      end
    end

    if ($urandom_range(0, 7) != 0) begin
      line_q.push_back(CHAR_STAR);
      repeat (2) line_q.push_back(field_chars[$urandom_range(0, 9)]);
      // occasionally more fields after the star
      if ($urandom_range(0, 5) == 0) begin
        line_q.push_back(CHAR_COMMA);
        line_q.push_back(8'($urandom_range(0, 255)));
      end
    end

    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(0, line_q.size());
      while (line_q.size() > cut) void'(line_q.pop_back());
    end

    foreach (line_q[i]) send_item(line_q[i], 1'b0);
    close_sentence();
  endtask

  task automatic test_random_sentences();
    int seq;
    seq = 0;
    while (items_sent < 920) begin
      send_random_sentence(seq);
      seq++;
    end
    settle();
  endtask

  // Raw line noise: random bytes of any value, '$' now and then up front
  task automatic test_line_noise();
    while (items_sent < 1120) begin
      gap_max = $urandom_range(0, 1) ? 0 : 8;
      if ($urandom_range(0, 2) == 0) send_item(CHAR_DOLLAR, 1'b0);
      repeat ($urandom_range(0, 12)) send_item(8'($urandom_range(0, 255)), 1'b0);
      close_sentence();
    end
    settle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_sentence();
    test_byte_extremes();
    test_star_inside_field();
    test_comma_saturation();
    test_random_sentences();
    test_line_noise();

    // let any stray result show itself before the verdict
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/nsfp_pkg.sv
src/nmea_sentence_field_parser.sv
dv/testbench.sv
